FILE: rtl/core/pvfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvfs_pkg
// Types and constants shared by the particle vector field step block.
// ----------------------------------------------------------------------------
package pvfs_pkg;

  localparam int FIELD_WIDTH_DEF  = 64;
  localparam int FIELD_HEIGHT_DEF = 64;

  localparam int TABLE_DEPTH = 4096;
  localparam int IDX_W       = 12;
  localparam int VEC_W       = 64;

  localparam int DIV_STAGES = 16;
  localparam int DIV_BPS    = 32 / DIV_STAGES;
  localparam int DEN_W      = 17;

  localparam int QUEUE_DEPTH = 32;
  localparam int OUT_DEPTH   = 8;

  localparam logic [31:0] FORCE_Q   = 32'd4587;
  localparam logic [8:0]  FORCE_SH  = 9'(4587 >> 4);
  localparam logic [30:0] LIFE_STEP = 31'(65536 / 30);
  localparam logic [31:0] CELL_BIAS = 32'd128;
  localparam logic [31:0] CELL_MASK = 32'hffffff00;

  localparam logic [16:0] DRAG_RST = 17'd62259;
  localparam logic [24:0] SPAN_RST = 25'd65536;

  typedef enum logic [2:0] {
    CFG_DRAG     = 3'd0,
    CFG_ORIGIN_X = 3'd1,
    CFG_ORIGIN_Y = 3'd2,
    CFG_SPAN_X   = 3'd3,
    CFG_SPAN_Y   = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_UPDATE = 1'b1
  } kind_e;

  typedef struct packed {
    logic              kind;
    logic [11:0]       entry_index;
    logic signed [31:0] entry_vec_x;
    logic signed [31:0] entry_vec_y;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [30:0]       life_left;
    logic signed [15:0] jitter_x;
    logic signed [15:0] jitter_y;
  } item_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic [30:0]       new_life;
  } result_t;

  typedef struct packed {
    logic [16:0] drag;
    logic [31:0] origin_x;
    logic [31:0] origin_y;
    logic [24:0] span_x;
    logic [24:0] span_y;
  } cfg_t;

  typedef struct packed {
    item_t            item;
    logic [IDX_W-1:0] addr;
  } job_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic empty;
  } queue_ctl_t;

endpackage

FILE: rtl/core/pvfs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvfs_if
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
interface pvfs_item_if;
  import pvfs_pkg::*;
  logic  valid;
  logic  ready;
  item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface pvfs_result_if;
  import pvfs_pkg::*;
  logic    valid;
  logic    ready;
  result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface pvfs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/particle_vector_field_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_vector_field_step
// Steers 16.16 particles through a stored vector-field table.
//
//   channel   dir  transaction
//   item_i    in   table write (kind 0) or particle update (kind 1)
//   result_o  out  updated position, velocity and life, one per update
//   cfg_i     in   register write: drag, field origin, field span
//
// One item per cycle sustained while the job queue has room. An update passes
// through two 16-stage pipelined dividers, then the job queue and a three-stage
// table lookup and integrate pipe. Reset clears control only; the table holds
// no defined value until written. Items are refused only when the 32-entry job
// queue is full counting items in flight.
// ----------------------------------------------------------------------------
module particle_vector_field_step #(
  parameter int FIELD_WIDTH  = pvfs_pkg::FIELD_WIDTH_DEF,
  parameter int FIELD_HEIGHT = pvfs_pkg::FIELD_HEIGHT_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pvfs_item_if.sink     item_i,
  pvfs_result_if.source result_o,
  pvfs_cfg_if.sink      cfg_i
);
  import pvfs_pkg::*;

  cfg_t       cfg_q;
  queue_ctl_t qctl;
  job_t       job, head;
  logic       push, pop, empty;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.drag     <= DRAG_RST;
      cfg_q.origin_x <= '0;
      cfg_q.origin_y <= '0;
      cfg_q.span_x   <= SPAN_RST;
      cfg_q.span_y   <= SPAN_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_DRAG:     cfg_q.drag     <= cfg_i.data[16:0];
        CFG_ORIGIN_X: cfg_q.origin_x <= cfg_i.data;
        CFG_ORIGIN_Y: cfg_q.origin_y <= cfg_i.data;
        CFG_SPAN_X:   cfg_q.span_x   <= cfg_i.data[24:0];
        CFG_SPAN_Y:   cfg_q.span_y   <= cfg_i.data[24:0];
        default: begin
        end
      endcase
    end
  end

  pvfs_front #(
    .FIELD_WIDTH  (FIELD_WIDTH),
    .FIELD_HEIGHT (FIELD_HEIGHT)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_i),
    .cfg_i  (cfg_q),
    .pop_i  (pop),
    .push_o (push),
    .job_o  (job)
  );

  assign qctl = '{push: push, pop: pop, empty: empty};

  pvfs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (qctl),
    .job_i   (job),
    .empty_o (empty),
    .head_o  (head)
  );

  pvfs_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .empty_i  (empty),
    .head_i   (head),
    .pop_o    (pop),
    .result_o (result_o)
  );

endmodule

FILE: rtl/core/pvfs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvfs_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module pvfs_ram #(
  parameter int Width = 64,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

FILE: rtl/core/pvfs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvfs_div
// Pipelined unsigned divider, 32-bit dividend, two quotient bits a stage.
// ----------------------------------------------------------------------------
module pvfs_div (
  input  logic                        clk_i,
  input  logic [31:0]                 num_i,
  input  logic [pvfs_pkg::DEN_W-1:0]  den_i,
  output logic [31:0]                 quo_o
);
  import pvfs_pkg::*;

  logic [DEN_W-1:0] rem_q [DIV_STAGES];
  logic [31:0]      wrk_q [DIV_STAGES];
  logic [DEN_W-1:0] rem_d [DIV_STAGES];
  logic [31:0]      wrk_d [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    always_comb begin
      logic [DEN_W-1:0] r;
      logic [31:0]      n;
      logic [DEN_W:0]   t;
      if (s == 0) begin
        r = '0;
        n = num_i;
      end else begin
        r = rem_q[s-1];
        n = wrk_q[s-1];
      end
      for (int j = 0; j < DIV_BPS; j++) begin
        t = {r, n[31]};
        n = {n[30:0], 1'b0};
        if (t >= {1'b0, den_i}) begin
          r    = DEN_W'(t - {1'b0, den_i});
          n[0] = 1'b1;
        end else begin
          r = t[DEN_W-1:0];
        end
      end
      rem_d[s] = r;
      wrk_d[s] = n;
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= rem_d[s];
      wrk_q[s] <= wrk_d[s];
    end
  end

  assign quo_o = wrk_q[DIV_STAGES-1];

endmodule

FILE: rtl/core/pvfs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvfs_front
// Accept items, map particle positions to a table cell, push jobs in order.
// ----------------------------------------------------------------------------
module pvfs_front #(
  parameter int FIELD_WIDTH  = pvfs_pkg::FIELD_WIDTH_DEF,
  parameter int FIELD_HEIGHT = pvfs_pkg::FIELD_HEIGHT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  pvfs_item_if.sink          item_i,
  input  pvfs_pkg::cfg_t     cfg_i,
  input  logic               pop_i,
  output logic               push_o,
  output pvfs_pkg::job_t     job_o
);
  import pvfs_pkg::*;

  localparam int SMag = 1;
  localparam int SQuo = SMag + DIV_STAGES;
  localparam int SPrd = SQuo + 1;
  localparam int SCel = SPrd + 1;
  localparam int NStg = SCel + 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int CwX  = $clog2(FIELD_WIDTH);
  localparam int CwY  = $clog2(FIELD_HEIGHT);
  localparam logic [31:0] LimX = 32'((FIELD_WIDTH - 2) * 256);
  localparam logic [31:0] LimY = 32'((FIELD_HEIGHT - 2) * 256);

  typedef struct packed {
    item_t item;
    logic  neg_x;
    logic  neg_y;
  } stage_t;

  stage_t          stg_q [NStg];
  logic [NStg-1:0] vld_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept;

  logic [31:0] dx, dy, mag_x_q, mag_y_q, quo_x, quo_y;
  logic [31:0] qs_x, qs_y, prd_x_q, prd_y_q, msk_x, msk_y;
  logic [DEN_W-1:0] den_x, den_y;
  logic [CwX-1:0] cel_x_q, cel_x_d;
  logic [CwY-1:0] cel_y_q, cel_y_d;
  logic [31:0] idx_full;

  assign item_i.ready = (cnt_q < CntW'(QUEUE_DEPTH));
  assign accept       = item_i.valid && item_i.ready;

  always_comb begin
    cnt_d = cnt_q;
    if (accept && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!accept && pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      vld_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      vld_q <= {vld_q[NStg-2:0], accept};
    end
  end

  assign dx = stg_q[0].item.pos_x - cfg_i.origin_x;
  assign dy = stg_q[0].item.pos_y - cfg_i.origin_y;

  assign den_x = (cfg_i.span_x[24:8] == '0) ? DEN_W'(1) : cfg_i.span_x[24:8];
  assign den_y = (cfg_i.span_y[24:8] == '0) ? DEN_W'(1) : cfg_i.span_y[24:8];

  always_ff @(posedge clk_i) begin
    stg_q[0] <= '{item: item_i.payload, neg_x: 1'b0, neg_y: 1'b0};
    stg_q[1] <= '{item: stg_q[0].item, neg_x: dx[31], neg_y: dy[31]};
    for (int k = 2; k < NStg; k++) begin
      stg_q[k] <= stg_q[k-1];
    end
    mag_x_q <= dx[31] ? (~dx + 32'd1) : dx;
    mag_y_q <= dy[31] ? (~dy + 32'd1) : dy;
    prd_x_q <= (qs_x + CELL_BIAS) * 32'(FIELD_WIDTH);
    prd_y_q <= (qs_y + CELL_BIAS) * 32'(FIELD_HEIGHT);
    cel_x_q <= cel_x_d;
    cel_y_q <= cel_y_d;
  end

  pvfs_div u_div_x (
    .clk_i (clk_i),
    .num_i (mag_x_q),
    .den_i (den_x),
    .quo_o (quo_x)
  );

  pvfs_div u_div_y (
    .clk_i (clk_i),
    .num_i (mag_y_q),
    .den_i (den_y),
    .quo_o (quo_y)
  );

  assign qs_x = stg_q[SQuo].neg_x ? (~quo_x + 32'd1) : quo_x;
  assign qs_y = stg_q[SQuo].neg_y ? (~quo_y + 32'd1) : quo_y;

  assign msk_x = prd_x_q & CELL_MASK;
  assign msk_y = prd_y_q & CELL_MASK;

  // clamp to 0 .. size-2
  always_comb begin
    if (msk_x[31]) begin
      cel_x_d = '0;
    end else if (msk_x > LimX) begin
      cel_x_d = CwX'(FIELD_WIDTH - 2);
    end else begin
      cel_x_d = msk_x[8 +: CwX];
    end
    if (msk_y[31]) begin
      cel_y_d = '0;
    end else if (msk_y > LimY) begin
      cel_y_d = CwY'(FIELD_HEIGHT - 2);
    end else begin
      cel_y_d = msk_y[8 +: CwY];
    end
  end

  assign idx_full = 32'(cel_y_q) * 32'(FIELD_WIDTH) + 32'(cel_x_q);

  assign push_o     = vld_q[SCel];
  assign job_o.item = stg_q[SCel].item;
  assign job_o.addr = (stg_q[SCel].item.kind == KIND_UPDATE) ? idx_full[IDX_W-1:0]
                                                              : stg_q[SCel].item.entry_index;

endmodule

FILE: rtl/core/pvfs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvfs_queue
// In-order job queue between the mapping front and the update back.
// ----------------------------------------------------------------------------
module pvfs_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pvfs_pkg::queue_ctl_t   ctl_i,
  input  pvfs_pkg::job_t         job_i,
  output logic                   empty_o,
  output pvfs_pkg::job_t         head_o
);
  import pvfs_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  job_t            buf_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (ctl_i.push) begin
        wp_q <= wp_q + PtrW'(1);
      end
      if (ctl_i.pop) begin
        rp_q <= rp_q + PtrW'(1);
      end
      if (ctl_i.push && !ctl_i.pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!ctl_i.push && ctl_i.pop) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      buf_q[wp_q] <= job_i;
    end
  end

  assign empty_o = (cnt_q == '0);
  assign head_o  = buf_q[rp_q];

endmodule

FILE: rtl/core/pvfs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvfs_back
// Apply table writes, look up vectors and integrate particle updates.
// ----------------------------------------------------------------------------
module pvfs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pvfs_pkg::cfg_t     cfg_i,
  input  logic               empty_i,
  input  pvfs_pkg::job_t     head_i,
  output logic               pop_o,
  pvfs_result_if.source      result_o
);
  import pvfs_pkg::*;

  localparam int PtrW = $clog2(OUT_DEPTH);
  localparam int CntW = $clog2(OUT_DEPTH + 1);

  logic              is_upd, ram_en, ram_we, out_acc, res_start;
  logic [VEC_W-1:0]  rdata;
  logic [CntW-1:0]   crd_q, ocnt_q;
  logic [PtrW-1:0]   wp_q, rp_q;
  result_t           ofifo_q [OUT_DEPTH];
  result_t           res;

  logic  b1_vld_q, b2_vld_q, b3_vld_q;
  item_t b1_q, b2_q, b3_q;

  logic signed [31:0] ax, ay, ax_q, ay_q;
  logic signed [27:0] sv_x, sv_y, sa_x, sa_y;
  logic signed [13:0] dg;
  logic signed [9:0]  fc;
  logic signed [41:0] pp_x, pp_y;
  logic signed [37:0] ap_x, ap_y;
  logic [31:0] pp_x_q, pp_y_q, ap_x_q, ap_y_q, npos_x, npos_y, npos_x_q, npos_y_q;

  assign is_upd    = (head_i.item.kind == KIND_UPDATE);
  assign pop_o     = !empty_i && (crd_q < CntW'(OUT_DEPTH));
  assign res_start = pop_o && is_upd;
  assign ram_en    = pop_o;
  assign ram_we    = !is_upd;
  assign out_acc   = result_o.valid && result_o.ready;

  pvfs_ram #(
    .Width (VEC_W),
    .Depth (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (head_i.addr),
    .wdata_i ({head_i.item.entry_vec_x, head_i.item.entry_vec_y}),
    .rdata_o (rdata)
  );

  // lookup and drag product
  assign ax   = rdata[63:32] + 32'(b1_q.jitter_x);
  assign ay   = rdata[31:0]  + 32'(b1_q.jitter_y);
  assign sv_x = 28'(b1_q.vel_x >>> 4);
  assign sv_y = 28'(b1_q.vel_y >>> 4);
  assign dg   = {1'b0, cfg_i.drag[16:4]};
  assign pp_x = sv_x * dg;
  assign pp_y = sv_y * dg;

  // position move and force product
  assign npos_x = b2_q.pos_x + {{12{pp_x_q[31]}}, pp_x_q[31:12]};
  assign npos_y = b2_q.pos_y + {{12{pp_y_q[31]}}, pp_y_q[31:12]};
  assign sa_x   = 28'(ax_q >>> 4);
  assign sa_y   = 28'(ay_q >>> 4);
  assign fc     = {1'b0, FORCE_SH};
  assign ap_x   = sa_x * fc;
  assign ap_y   = sa_y * fc;

  // velocity and life
  always_comb begin
    res.new_pos_x = npos_x_q;
    res.new_pos_y = npos_y_q;
    res.new_vel_x = b3_q.vel_x + {{12{ap_x_q[31]}}, ap_x_q[31:12]};
    res.new_vel_y = b3_q.vel_y + {{12{ap_y_q[31]}}, ap_y_q[31:12]};
    res.new_life  = (b3_q.life_left >= LIFE_STEP) ? (b3_q.life_left - LIFE_STEP) : '0;
  end

  always_ff @(posedge clk_i) begin
    b1_q     <= head_i.item;
    b2_q     <= b1_q;
    b3_q     <= b2_q;
    ax_q     <= ax;
    ay_q     <= ay;
    pp_x_q   <= pp_x[31:0];
    pp_y_q   <= pp_y[31:0];
    npos_x_q <= npos_x;
    npos_y_q <= npos_y;
    ap_x_q   <= 32'(ap_x);
    ap_y_q   <= 32'(ap_y);
    if (b3_vld_q) begin
      ofifo_q[wp_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q <= 1'b0;
      b2_vld_q <= 1'b0;
      b3_vld_q <= 1'b0;
      crd_q    <= '0;
      ocnt_q   <= '0;
      wp_q     <= '0;
      rp_q     <= '0;
    end else begin
      b1_vld_q <= res_start;
      b2_vld_q <= b1_vld_q;
      b3_vld_q <= b2_vld_q;
      if (res_start && !out_acc) begin
        crd_q <= crd_q + CntW'(1);
      end else if (!res_start && out_acc) begin
        crd_q <= crd_q - CntW'(1);
      end
      if (b3_vld_q) begin
        wp_q <= wp_q + PtrW'(1);
      end
      if (out_acc) begin
        rp_q <= rp_q + PtrW'(1);
      end
      if (b3_vld_q && !out_acc) begin
        ocnt_q <= ocnt_q + CntW'(1);
      end else if (!b3_vld_q && out_acc) begin
        ocnt_q <= ocnt_q - CntW'(1);
      end
    end
  end

  assign result_o.valid   = (ocnt_q != '0);
  assign result_o.payload = ofifo_q[rp_q];

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the particle vector field step block against its own predictor.
// Table writes, directed particle updates and random updates under several
// register settings; both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
  import pvfs_pkg::*;

  logic clk_i;
  logic rst_ni;

  pvfs_item_if   item_ch ();
  pvfs_result_if result_ch ();
  pvfs_cfg_if    cfg_ch ();

  particle_vector_field_step i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_ch.sink),
    .result_o (result_ch.source),
    .cfg_i    (cfg_ch.sink)
  );

  localparam int GRID_W   = FIELD_WIDTH_DEF;
  localparam int GRID_H   = FIELD_HEIGHT_DEF;
  localparam int DOG_MAX  = 20000;

  logic [31:0] vec_x_mem [TABLE_DEPTH];
  logic [31:0] vec_y_mem [TABLE_DEPTH];
  bit          written   [TABLE_DEPTH];
  cfg_t        regs;
  result_t     pending_q[$];
  int          n_errors;
  int          n_updates;
  int          n_results;
  int          n_writes;
  bit          calm;
  int          dog;

  initial begin
    clk_i = 1'b0;
    forever begin
      #1 clk_i = 1'b1;
      #1 clk_i = 1'b0;
    end
  end

  function automatic logic [31:0] grid_cell(logic [31:0] p, logic [31:0] org,
                                            logic [24:0] span, int size);
    longint d;
    longint q;
    longint c;
    logic [31:0] g;
    d = longint'(span >> 8);
    if (d == 0) d = 1;
    q = longint'($signed(p - org)) / d;
    g = 32'(q) + CELL_BIAS;
    g = (g * 32'(size)) & CELL_MASK;
    c = longint'($signed(g));
    if (c < 0) c = 0;
    if (c > (longint'(size) - 2) * 256) c = (longint'(size) - 2) * 256;
    return 32'(c >>> 8);
  endfunction

  function automatic logic [31:0] nudge(logic [31:0] v, logic [31:0] s,
                                        logic [31:0] f);
    logic [31:0] m;
    m = 32'($signed(s) >>> 4) * (f >> 4);
    return v + 32'($signed(m) >>> 12);
  endfunction

  function automatic logic [11:0] entry_of(logic [31:0] px, logic [31:0] py);
    logic [31:0] cx;
    logic [31:0] cy;
    cx = grid_cell(px, regs.origin_x, regs.span_x, GRID_W);
    cy = grid_cell(py, regs.origin_y, regs.span_y, GRID_H);
    return 12'(cy * GRID_W + cx);
  endfunction

  task automatic predict_step(item_t it);
    logic [11:0] a;
    result_t     r;
    longint      l;
    if (it.kind == KIND_WRITE) begin
      vec_x_mem[it.entry_index] = it.entry_vec_x;
      vec_y_mem[it.entry_index] = it.entry_vec_y;
      written[it.entry_index]   = 1'b1;
      n_writes++;
    end else begin
      a = entry_of(it.pos_x, it.pos_y);
      r.new_pos_x = nudge(it.pos_x, it.vel_x, 32'(regs.drag));
      r.new_pos_y = nudge(it.pos_y, it.vel_y, 32'(regs.drag));
      r.new_vel_x = nudge(it.vel_x, vec_x_mem[a] + 32'($signed(it.jitter_x)), FORCE_Q);
      r.new_vel_y = nudge(it.vel_y, vec_y_mem[a] + 32'($signed(it.jitter_y)), FORCE_Q);
      l = longint'(it.life_left) - longint'(LIFE_STEP);
      r.new_life = (l < 0) ? 31'd0 : 31'(l);
      pending_q.push_back(r);
      n_updates++;
    end
  endtask

  task automatic gap();
    if (!calm) begin
      while ($urandom_range(99) < 28) begin
        item_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
  endtask

  task automatic put_item(item_t it);
    gap();
    item_ch.valid   <= 1'b1;
    item_ch.payload <= it;
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
    predict_step(it);
  endtask

  function automatic item_t blank_update();
    item_t it;
    it = '0;
    it.kind        = KIND_UPDATE;
    it.entry_index = 12'($urandom);
    it.entry_vec_x = $urandom;
    it.entry_vec_y = $urandom;
    it.pos_x       = $urandom;
    it.pos_y       = $urandom;
    it.vel_x       = $urandom;
    it.vel_y       = $urandom;
    it.life_left   = 31'($urandom);
    it.jitter_x    = 16'(int'($urandom_range(45874)) - 32768);
    it.jitter_y    = 16'(int'($urandom_range(45874)) - 32768);
    return it;
  endfunction

  // load the target entry first when an update would hit an empty one
  task automatic send_item(item_t it);
    item_t       wr;
    logic [11:0] a;
    if (it.kind == KIND_UPDATE) begin
      a = entry_of(it.pos_x, it.pos_y);
      if (!written[a]) begin
        wr             = blank_update();
        wr.kind        = KIND_WRITE;
        wr.entry_index = a;
        put_item(wr);
      end
    end
    put_item(it);
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_DRAG:     regs.drag     = val[16:0];
      CFG_ORIGIN_X: regs.origin_x = val;
      CFG_ORIGIN_Y: regs.origin_y = val;
      CFG_SPAN_X:   regs.span_x   = val[24:0];
      CFG_SPAN_Y:   regs.span_y   = val[24:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic test_directed();
    item_t it;
    logic [31:0] edges[4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
    it = blank_update();
    it.kind        = KIND_WRITE;
    it.entry_index = 12'h000;
    it.entry_vec_x = 32'h8000_0000;
    it.entry_vec_y = 32'h7fff_ffff;
    send_item(it);
    for (int i = 0; i < 16; i++) begin
      it           = blank_update();
      it.pos_x     = edges[i % 4];
      it.pos_y     = edges[(i / 4) % 4];
      it.vel_x     = edges[(i + 1) % 4];
      it.vel_y     = edges[(i + 2) % 4];
      it.life_left = (i % 3 == 0) ? 31'h7fff_ffff : 31'(i * 1000);
      it.jitter_x  = (i % 2 != 0) ? -16'sd32768 : 16'sd13106;
      it.jitter_y  = (i % 2 != 0) ? 16'sd13106 : -16'sd32768;
      send_item(it);
    end
    it = blank_update();
    it.life_left = LIFE_STEP;
    send_item(it);
    it.life_left = LIFE_STEP - 1;
    send_item(it);
    it = blank_update();
    it.kind = KIND_WRITE;
    it.entry_index = 12'hfff;
    it.entry_vec_x = 32'h7fff_ffff;
    it.entry_vec_y = 32'h8000_0000;
    send_item(it);
    drain();
  endtask

  task automatic test_random(int n);
    item_t it;
    for (int i = 0; i < n; i++) begin
      it = blank_update();
      if ($urandom_range(9) == 0) it.kind = KIND_WRITE;
      else if ($urandom_range(3) == 0) begin
        it.pos_x = regs.origin_x + 32'(int'($urandom_range(8192)) - 4096) * (regs.span_x >> 8);
        it.pos_y = regs.origin_y + 32'(int'($urandom_range(8192)) - 4096) * (regs.span_y >> 8);
      end
      send_item(it);
    end
  endtask

  task automatic test_settings();
    write_reg(CFG_DRAG, 32'd131071);
    write_reg(CFG_ORIGIN_X, 32'h8000_0000);
    write_reg(CFG_ORIGIN_Y, 32'h7fff_ffff);
    write_reg(CFG_SPAN_X, 32'd256);
    write_reg(CFG_SPAN_Y, 32'd16777216);
    test_random(110);
    drain();
    write_reg(CFG_DRAG, 32'd0);
    write_reg(CFG_ORIGIN_X, 32'h0001_0000);
    write_reg(CFG_ORIGIN_Y, 32'hffff_0000);
    write_reg(CFG_SPAN_X, 32'd16777216);
    write_reg(CFG_SPAN_Y, 32'd255);
    test_random(110);
    drain();
    write_reg(CFG_DRAG, 32'($urandom_range(131071)));
    write_reg(CFG_ORIGIN_X, $urandom);
    write_reg(CFG_ORIGIN_Y, $urandom);
    write_reg(CFG_SPAN_X, 32'($urandom_range(16777216, 256)));
    write_reg(CFG_SPAN_Y, 32'($urandom_range(16777216, 256)));
    test_random(110);
    drain();
  endtask

  initial begin
    regs           = '{drag: DRAG_RST, origin_x: '0, origin_y: '0,
                       span_x: SPAN_RST, span_y: SPAN_RST};
    n_errors       = 0;
    n_updates      = 0;
    n_results      = 0;
    n_writes       = 0;
    calm           = 1'b0;
    rst_ni         = 1'b0;
    item_ch.valid  = 1'b0;
    item_ch.payload = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = CFG_DRAG;
    cfg_ch.data    = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    calm = 1'b1;
    test_random(180);
    calm = 1'b0;
    drain();
    test_settings();
    $display("Covered %0d updates and %0d table writes over four register settings,",
             n_updates, n_writes);
    $display("with random idling on both channels; %0d results checked.", n_results);
    if (n_errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      result_ch.ready <= calm || ($urandom_range(99) >= 28);
    end
  end

  always @(posedge clk_i) begin
    result_t exp_r;
    result_t got;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      got = result_ch.payload;
      n_results++;
      if (pending_q.size() == 0) begin
        $display("%0t: result with none expected: %h", $time, got);
        n_errors++;
      end else begin
        exp_r = pending_q.pop_front();
        if (got.new_pos_x !== exp_r.new_pos_x) begin
          $display("%0t: new_pos_x exp %h got %h", $time, exp_r.new_pos_x, got.new_pos_x);
          n_errors++;
        end
        if (got.new_pos_y !== exp_r.new_pos_y) begin
          $display("%0t: new_pos_y exp %h got %h", $time, exp_r.new_pos_y, got.new_pos_y);
          n_errors++;
        end
        if (got.new_vel_x !== exp_r.new_vel_x) begin
          $display("%0t: new_vel_x exp %h got %h", $time, exp_r.new_vel_x, got.new_vel_x);
          n_errors++;
        end
        if (got.new_vel_y !== exp_r.new_vel_y) begin
          $display("%0t: new_vel_y exp %h got %h", $time, exp_r.new_vel_y, got.new_vel_y);
          n_errors++;
        end
        if (got.new_life !== exp_r.new_life) begin
          $display("%0t: new_life exp %h got %h", $time, exp_r.new_life, got.new_life);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready) || pending_q.size() == 0) begin
      dog <= 0;
    end else if (dog >= DOG_MAX) begin
      $display("tb failed");
      $finish;
    end else begin
      dog <= dog + 1;
    end
  end

endmodule

FILE: files.f
rtl/core/pvfs_pkg.sv
rtl/core/pvfs_if.sv
rtl/core/pvfs_ram.sv
rtl/core/pvfs_div.sv
rtl/core/pvfs_front.sv
rtl/core/pvfs_queue.sv
rtl/core/pvfs_back.sv
rtl/core/particle_vector_field_step.sv
verif/tb.sv
